// File: rtl/text_mode_glyph_pixel_generator_macros.svh
// Assertion macros shared by the generator and serializer RTL files.
`ifndef TEXT_MODE_GLYPH_PIXEL_GENERATOR_MACROS_SVH
`define TEXT_MODE_GLYPH_PIXEL_GENERATOR_MACROS_SVH

// Checked on every rising edge while reset is released.
`define TMG_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TMG_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/tmg_pkg.sv
package tmg_pkg;

    localparam int TEXT_COLS   = 40;
    localparam int TEXT_ROWS   = 25;
    localparam int GLYPH_BYTES = 2048;
    localparam int GA_W        = $clog2(GLYPH_BYTES);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    localparam logic [31:0] ALPHA_BITS   = 32'h7F00_0000;
    localparam logic [31:0] INTENSE_GRAY = 32'h007F_7F7F;
    localparam logic [7:0]  CHANNEL_STEP = 8'h7F;

    typedef struct packed {
        logic [7:0]  bits;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [5:0]  col;
        logic [7:0]  y;
    } t_row;

    function automatic logic [31:0] make_colour(input logic [3:0] nib);
        logic [31:0] c;
        c = ALPHA_BITS;
        if (nib[3]) c = c + INTENSE_GRAY;
        if (nib[2]) c = c + {8'd0, CHANNEL_STEP, 16'd0};
        if (nib[1]) c = c + {16'd0, CHANNEL_STEP, 8'd0};
        if (nib[0]) c = c + {24'd0, CHANNEL_STEP};
        return c;
    endfunction

    function automatic logic [GA_W-1:0] to_ram_addr(input logic [10:0] a);
        logic [11:0] w;
        w = {1'b0, a};
        return w[GA_W-1:0];
    endfunction

endpackage

// File: rtl/text_mode_glyph_pixel_generator.sv
// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready   i_s_tdata[55:0], i_s_tuser (func)
// m         out        o_m_tvalid / i_m_tready   o_m_tdata[55:0], o_m_tlast (last pixel)
//
// A render beat inside the text grid yields eight pixel beats, one per cycle while the
// output is ready; the pixel shifter bounds the render rate; writes go to glyph RAM.
// The glyph row is read from the single-port glyph RAM in the accept cycle and is
// held in a one-row buffer until the shifter frees, so input is taken during output.
// Reset is synchronous; the glyph RAM is not cleared and needs no clearing pass.
// A stall on the output holds the current pixel and, once the buffer is full, the input.
`include "text_mode_glyph_pixel_generator_macros.svh"

module text_mode_glyph_pixel_generator
    import tmg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0: glyph_addr[10:0], glyph_byte[18:11], char_code[26:19],
    // attribute[34:27], glyph_line[37:35], cell_col[43:38], cell_row[48:44], zero fill.
    input  logic [55:0] i_s_tdata,
    // Fields from bit 0: func.
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: pixel_argb[31:0], pixel_x[40:32], pixel_y[48:41], zero fill.
    output logic [55:0] o_m_tdata,
    output logic        o_m_tlast
);

    logic [10:0]     w_addr;
    logic [7:0]      w_byte;
    logic [7:0]      w_code;
    logic [7:0]      w_attr;
    logic [2:0]      w_line;
    logic [5:0]      w_col;
    logic [4:0]      w_row;
    logic [10:0]     w_gaddr;
    logic            w_acc;
    logic            w_in_grid;
    logic            w_wr_ok;
    logic            w_rd_ok;
    logic            w_render;
    logic            w_ram_en;
    logic            w_ram_we;
    logic [GA_W-1:0] w_ram_addr;
    logic [7:0]      w_rdata;
    logic            w_load_ready;
    logic            w_h_move;
    t_row            w_load;

    logic            r_p_v;
    logic            r_p_zero;
    logic [7:0]      r_p_attr;
    logic [5:0]      r_p_col;
    logic [7:0]      r_p_y;
    logic            r_h_v;
    logic [7:0]      r_h_bits;
    logic [7:0]      r_h_attr;
    logic [5:0]      r_h_col;
    logic [7:0]      r_h_y;

    assign w_addr  = i_s_tdata[10:0];
    assign w_byte  = i_s_tdata[18:11];
    assign w_code  = i_s_tdata[26:19];
    assign w_attr  = i_s_tdata[34:27];
    assign w_line  = i_s_tdata[37:35];
    assign w_col   = i_s_tdata[43:38];
    assign w_row   = i_s_tdata[48:44];
    assign w_gaddr = {w_code, w_line};

    assign o_s_tready = !r_p_v && !r_h_v;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_in_grid  = ({26'd0, w_col} < 32'(TEXT_COLS)) && ({27'd0, w_row} < 32'(TEXT_ROWS));
    assign w_wr_ok    = {21'd0, w_addr} < 32'(GLYPH_BYTES);
    assign w_rd_ok    = {21'd0, w_gaddr} < 32'(GLYPH_BYTES);
    assign w_render   = w_acc && (i_s_tuser == FUNC_RENDER) && w_in_grid;

    // Reads happen only in the accept cycle, so a read and a write never share a cycle.
    assign w_ram_we   = (i_s_tuser == FUNC_WRITE);
    assign w_ram_en   = w_acc && (w_ram_we ? w_wr_ok : (w_in_grid && w_rd_ok));
    assign w_ram_addr = w_ram_we ? to_ram_addr(w_addr) : to_ram_addr(w_gaddr);

    tmg_ram #(
        .WIDTH(8),
        .DEPTH(GLYPH_BYTES)
    ) u_glyph_ram (
        .i_clk  (i_clk),
        .i_en   (w_ram_en),
        .i_we   (w_ram_we),
        .i_addr (w_ram_addr),
        .i_wdata(w_byte),
        .o_rdata(w_rdata)
    );

    assign w_h_move = r_h_v && w_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_h_v <= 1'b0;
        end else begin
            r_p_v <= w_render;
            r_h_v <= r_p_v || (r_h_v && !w_h_move);
        end
        if (w_render) begin
            r_p_zero <= !w_rd_ok;
            r_p_attr <= w_attr;
            r_p_col  <= w_col;
            r_p_y    <= {w_row, w_line};
        end
        if (r_p_v) begin
            r_h_bits <= r_p_zero ? 8'd0 : w_rdata;
            r_h_attr <= r_p_attr;
            r_h_col  <= r_p_col;
            r_h_y    <= r_p_y;
        end
    end

    always_comb begin
        w_load.bits = r_h_bits;
        w_load.fg   = make_colour(r_h_attr[3:0]);
        w_load.bg   = make_colour(r_h_attr[7:4]);
        w_load.col  = r_h_col;
        w_load.y    = r_h_y;
    end

    tmg_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_valid(r_h_v),
        .i_load      (w_load),
        .o_load_ready(w_load_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    `TMG_ASSERT(a_read_lands_in_free_buffer, i_clk, i_rst_n, r_p_v |-> !r_h_v || w_h_move, "glyph read data would overwrite a held row")
    `TMG_ASSERT(a_render_issues_read, i_clk, i_rst_n, w_render |-> w_ram_en || !w_rd_ok, "in-store render did not read the glyph RAM")
    `TMG_ASSERT(a_held_row_waits, i_clk, i_rst_n, r_h_v && !w_h_move |=> r_h_v && $stable(r_h_bits), "held glyph row lost while the shifter was busy")

endmodule

// File: rtl/tmg_ram.sv
module tmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tmg_serializer.sv
`include "text_mode_glyph_pixel_generator_macros.svh"

module tmg_serializer
    import tmg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load_valid,
    input  t_row        i_load,
    output logic        o_load_ready,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: pixel_argb[31:0], pixel_x[40:32], pixel_y[48:41], zero fill.
    output logic [55:0] o_m_tdata,
    output logic        o_m_tlast
);

    logic        r_v;
    logic [2:0]  r_cnt;
    t_row        r_row;
    logic        n_v;
    logic [2:0]  n_cnt;
    t_row        n_row;
    logic        w_beat;
    logic        w_end;
    logic [31:0] w_argb;
    logic [8:0]  w_x;

    assign w_beat       = r_v && i_m_tready;
    assign w_end        = w_beat && (r_cnt == 3'd7);
    assign o_load_ready = !r_v || w_end;

    always_comb begin
        n_v   = r_v;
        n_cnt = r_cnt;
        n_row = r_row;
        if (w_beat) begin
            n_cnt      = r_cnt + 3'd1;
            n_row.bits = {r_row.bits[6:0], 1'b0};
            if (w_end) begin
                n_v = 1'b0;
            end
        end
        if (i_load_valid && o_load_ready) begin
            n_v   = 1'b1;
            n_cnt = 3'd0;
            n_row = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_cnt <= 3'd0;
        end else begin
            r_v   <= n_v;
            r_cnt <= n_cnt;
        end
        r_row <= n_row;
    end

    assign w_argb     = r_row.bits[7] ? r_row.fg : r_row.bg;
    assign w_x        = {r_row.col, r_cnt};
    assign o_m_tvalid = r_v;
    assign o_m_tdata  = {7'd0, r_row.y, w_x, w_argb};
    assign o_m_tlast  = (r_cnt == 3'd7);

    `TMG_ASSERT(a_end_without_load_idles, i_clk, i_rst_n, w_end && !i_load_valid |=> !o_m_tvalid, "row ended but output stayed valid")
    `TMG_ASSERT(a_mid_row_stays_valid, i_clk, i_rst_n, w_beat && !o_m_tlast |=> o_m_tvalid && (r_cnt == $past(r_cnt) + 3'd1), "row dropped before its eighth pixel")
    `TMG_ASSERT_ALWAYS(a_reset_idles, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid right after reset")

endmodule
